FILE: hdl/frc_pkg.sv
// ----------------------------------------------------------------------------
// frc_pkg
// Shared widths, constants, reciprocal tables and sideband types for the
// fractional-N PLL rate calculator.
// ----------------------------------------------------------------------------
package frc_pkg;

  localparam int RefW  = 26;
  localparam int FW    = 27;
  localparam int MagW  = 10;
  localparam int ProdW = 36;
  localparam int DivW  = 11;
  localparam int RateW = 31;
  localparam int PdK   = 31;
  localparam int BusK  = 34;
  localparam int PerK  = 33;

  localparam logic [RefW-1:0]  LowRefHz     = 26'd33554432;
  localparam logic [RefW-1:0]  HighRefReset = 26'd26000000;
  localparam logic [3:0]       MinIntFactor = 4'd5;
  localparam logic [1:0]       SelLowOsc    = 2'd1;
  localparam logic [RateW-1:0] RateMax      = 31'h7FFF_FFFF;

  // Ceiling reciprocals scaled by 2**PdK; exact for dividends below 2**27.
  function automatic logic [31:0] pd_recip(input logic [3:0] pd);
    logic [31:0] r;
    unique case (pd)
      4'd0:  r = 32'd2147483648;
      4'd1:  r = 32'd1073741824;
      4'd2:  r = 32'd715827883;
      4'd3:  r = 32'd536870912;
      4'd4:  r = 32'd429496730;
      4'd5:  r = 32'd357913942;
      4'd6:  r = 32'd306783379;
      4'd7:  r = 32'd268435456;
      4'd8:  r = 32'd238609295;
      4'd9:  r = 32'd214748365;
      4'd10: r = 32'd195225787;
      4'd11: r = 32'd178956971;
      4'd12: r = 32'd165191050;
      4'd13: r = 32'd153391690;
      4'd14: r = 32'd143165577;
      default: r = 32'd134217728;
    endcase
    return r;
  endfunction

  // Scaled by 2**BusK; exact for dividends below 2**31.
  function automatic logic [34:0] bus_recip(input logic [2:0] code);
    logic [34:0] r;
    unique case (code)
      3'd0: r = 35'd17179869184;
      3'd1: r = 35'd8589934592;
      3'd2: r = 35'd5726623062;
      3'd3: r = 35'd4294967296;
      3'd4: r = 35'd3435973837;
      3'd5: r = 35'd2863311531;
      3'd6: r = 35'd2454267027;
      default: r = 35'd2147483648;
    endcase
    return r;
  endfunction

  // Scaled by 2**PerK; exact for dividends below 2**31.
  function automatic logic [33:0] per_recip(input logic [1:0] code);
    logic [33:0] r;
    unique case (code)
      2'd0: r = 34'd8589934592;
      2'd1: r = 34'd4294967296;
      2'd2: r = 34'd2863311531;
      default: r = 34'd2147483648;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic [RateW-1:0] fmi;
    logic             neg;
    logic             pass;
    logic [RefW-1:0]  ref_hz;
    logic [2:0]       busd;
    logic [1:0]       perd;
  } frc_side_t;

  typedef struct packed {
    logic [1:0] ref_select;
    logic       pll_enable;
    logic       pll_bypass;
    logic [3:0] pre_divider;
    logic [9:0] frac_denominator;
    logic [3:0] integer_factor;
    logic [9:0] frac_numerator;
    logic [2:0] bus_divider;
    logic [1:0] periph_divider;
  } frc_req_t;

endpackage

FILE: hdl/frc_if.sv
// ----------------------------------------------------------------------------
// frc_req_if / frc_rsp_if
// Valid/ready channels for rate requests and rate results.
// ----------------------------------------------------------------------------
interface frc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] ref_select;
  logic       pll_enable;
  logic       pll_bypass;
  logic [3:0] pre_divider;
  logic [9:0] frac_denominator;
  logic [3:0] integer_factor;
  logic signed [9:0] frac_numerator;
  logic [2:0] bus_divider;
  logic [1:0] periph_divider;

  modport source (output valid, ref_select, pll_enable, pll_bypass, pre_divider,
                  frac_denominator, integer_factor, frac_numerator, bus_divider,
                  periph_divider, input ready);
  modport sink (input valid, ref_select, pll_enable, pll_bypass, pre_divider,
                frac_denominator, integer_factor, frac_numerator, bus_divider,
                periph_divider, output ready);
endinterface

interface frc_rsp_if;
  logic        valid;
  logic        ready;
  logic [30:0] main_rate_hz;
  logic [30:0] bus_rate_hz;
  logic [30:0] periph_rate_hz;
  logic        rate_clamped;

  modport source (output valid, main_rate_hz, bus_rate_hz, periph_rate_hz,
                  rate_clamped, input ready);
  modport sink (input valid, main_rate_hz, bus_rate_hz, periph_rate_hz,
                rate_clamped, output ready);
endinterface

FILE: hdl/frc_front.sv
// ----------------------------------------------------------------------------
// frc_front
// Reference select, pre-divider by reciprocal, and the two products that
// feed the fraction divider and the integer term.
// ----------------------------------------------------------------------------
module frc_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  frc_pkg::frc_req_t      in_req,
  input  logic [25:0]            high_ref_hz,
  output logic                   out_valid,
  output logic [35:0]            out_prod,
  output logic [10:0]            out_dvs,
  output frc_pkg::frc_side_t     out_side
);
  import frc_pkg::*;

  // Stage A: captured settings.
  logic              a_valid;
  logic [RefW-1:0]   a_ref;
  logic [31:0]       a_recip;
  logic [3:0]        a_mfi;
  logic [MagW-1:0]   a_mag;
  logic              a_neg;
  logic              a_pass;
  logic [DivW-1:0]   a_dvs;
  logic [2:0]        a_busd;
  logic [1:0]        a_perd;

  // Stage B: pre-divided reference.
  logic              b_valid;
  logic [FW-1:0]     b_f;
  logic [3:0]        b_mfi;
  logic [MagW-1:0]   b_mag;
  logic              b_neg;
  logic              b_pass;
  logic [RefW-1:0]   b_ref;
  logic [DivW-1:0]   b_dvs;
  logic [2:0]        b_busd;
  logic [1:0]        b_perd;

  logic [MagW-1:0]   mag_in;
  logic [58:0]       f_full;

  assign mag_in = in_req.frac_numerator[9] ? (10'h000 - in_req.frac_numerator)
                                           : in_req.frac_numerator;
  assign f_full = {32'd0, a_ref, 1'b0} * {27'd0, a_recip};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ref   <= (in_req.ref_select == SelLowOsc) ? LowRefHz : high_ref_hz;
      a_recip <= pd_recip(in_req.pre_divider);
      a_mfi   <= (in_req.integer_factor < MinIntFactor) ? MinIntFactor
                                                        : in_req.integer_factor;
      a_mag   <= mag_in;
      a_neg   <= in_req.frac_numerator[9];
      a_pass  <= !in_req.pll_enable || in_req.pll_bypass;
      a_dvs   <= {1'b0, in_req.frac_denominator} + 11'd1;
      a_busd  <= in_req.bus_divider;
      a_perd  <= in_req.periph_divider;

      b_f    <= f_full[PdK+FW-1:PdK];
      b_mfi  <= a_mfi;
      b_mag  <= a_mag;
      b_neg  <= a_neg;
      b_pass <= a_pass;
      b_ref  <= a_ref;
      b_dvs  <= a_dvs;
      b_busd <= a_busd;
      b_perd <= a_perd;

      out_prod        <= {9'd0, b_f} * {26'd0, b_mag};
      out_side.fmi    <= {4'd0, b_f} * {27'd0, b_mfi};
      out_side.neg    <= b_neg;
      out_side.pass   <= b_pass;
      out_side.ref_hz <= b_ref;
      out_side.busd   <= b_busd;
      out_side.perd   <= b_perd;
      out_dvs         <= b_dvs;
    end
  end

endmodule

FILE: hdl/frc_div.sv
// ----------------------------------------------------------------------------
// frc_div
// Pipelined restoring divider, one quotient bit per stage, for the
// fraction term of the feedback factor.
// ----------------------------------------------------------------------------
module frc_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  logic [35:0]            in_num,
  input  logic [10:0]            in_dvs,
  input  frc_pkg::frc_side_t     in_side,
  output logic                   out_valid,
  output logic [35:0]            out_quo,
  output frc_pkg::frc_side_t     out_side
);
  import frc_pkg::*;

  localparam int Steps = ProdW;

  logic              vld  [Steps];
  logic [DivW-1:0]   rem  [Steps];
  logic [ProdW-1:0]  word [Steps];
  logic [DivW-1:0]   dvs  [Steps];
  frc_side_t         side [Steps];

  for (genvar i = 0; i < Steps; i++) begin : g_stage
    logic              cur_vld;
    logic [DivW-1:0]   cur_rem;
    logic [ProdW-1:0]  cur_word;
    logic [DivW-1:0]   cur_dvs;
    frc_side_t         cur_side;
    logic [DivW:0]     trial;
    logic [DivW:0]     diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign cur_vld  = in_valid;
      assign cur_rem  = '0;
      assign cur_word = in_num;
      assign cur_dvs  = in_dvs;
      assign cur_side = in_side;
    end else begin : g_next
      assign cur_vld  = vld[i-1];
      assign cur_rem  = rem[i-1];
      assign cur_word = word[i-1];
      assign cur_dvs  = dvs[i-1];
      assign cur_side = side[i-1];
    end

    assign trial = {cur_rem, cur_word[ProdW-1]};
    assign diff  = trial - {1'b0, cur_dvs};
    assign ge    = trial >= {1'b0, cur_dvs};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv) begin
        vld[i] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[i]  <= ge ? diff[DivW-1:0] : trial[DivW-1:0];
        word[i] <= {cur_word[ProdW-2:0], ge};
        dvs[i]  <= cur_dvs;
        side[i] <= cur_side;
      end
    end
  end

  assign out_valid = vld[Steps-1];
  assign out_quo   = word[Steps-1];
  assign out_side  = side[Steps-1];

endmodule

FILE: hdl/frc_back.sv
// ----------------------------------------------------------------------------
// frc_back
// Combines integer and fraction terms with saturation, then derives the
// bus and peripheral rates by reciprocal multiplication.
// ----------------------------------------------------------------------------
module frc_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  logic [35:0]            in_frac,
  input  frc_pkg::frc_side_t     in_side,
  output logic                   out_valid,
  output logic [30:0]            out_main,
  output logic [30:0]            out_bus,
  output logic [30:0]            out_per,
  output logic                   out_clamped
);
  import frc_pkg::*;

  logic signed [37:0] total;
  logic               over;
  logic               under;

  logic               m_valid;
  logic [RateW-1:0]   m_main;
  logic               m_clamped;
  logic [2:0]         m_busd;
  logic [1:0]         m_perd;

  logic               n_valid;
  logic [RateW-1:0]   n_main;
  logic [RateW-1:0]   n_bus;
  logic               n_clamped;
  logic [1:0]         n_perd;

  logic [65:0]        bus_full;
  logic [64:0]        per_full;

  always_comb begin
    if (in_side.neg) begin
      total = $signed({7'd0, in_side.fmi}) - $signed({2'b00, in_frac});
    end else begin
      total = $signed({7'd0, in_side.fmi}) + $signed({2'b00, in_frac});
    end
    under = total < 38'sd0;
    over  = total > $signed({7'd0, RateMax});
  end

  assign bus_full = {35'd0, m_main} * {31'd0, bus_recip(m_busd)};
  assign per_full = {34'd0, n_bus} * {31'd0, per_recip(n_perd)};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      n_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      m_valid   <= in_valid;
      n_valid   <= m_valid;
      out_valid <= n_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      priority if (in_side.pass) begin
        m_main    <= {5'd0, in_side.ref_hz};
        m_clamped <= 1'b0;
      end else if (under) begin
        m_main    <= '0;
        m_clamped <= 1'b1;
      end else if (over) begin
        m_main    <= RateMax;
        m_clamped <= 1'b1;
      end else begin
        m_main    <= total[RateW-1:0];
        m_clamped <= 1'b0;
      end
      m_busd <= in_side.busd;
      m_perd <= in_side.perd;

      n_main    <= m_main;
      n_bus     <= bus_full[BusK+RateW-1:BusK];
      n_clamped <= m_clamped;
      n_perd    <= m_perd;

      out_main    <= n_main;
      out_bus     <= n_bus;
      out_per     <= per_full[PerK+RateW-1:PerK];
      out_clamped <= n_clamped;
    end
  end

endmodule

FILE: hdl/fractional_pll_rate_calc_core.sv
// ----------------------------------------------------------------------------
// fractional_pll_rate_calc_core
// Computes the main, bus and peripheral clock rates that a fractional-N PLL
// setting produces, with saturation of the main rate.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake     Payload
//   -------  ---  ------------  ------------------------------------------
//   req      in   valid/ready   PLL settings and post-divider codes
//   rsp      out  valid/ready   main, bus, peripheral rate and clamp flag
//   cfg      in   cfg_write_en  high reference frequency in Hz (26 bits)
//
// One item enters per cycle unless rsp stalls; its result passes through
// three front stages, 36 fraction divider stages and three back stages.
// Most of that depth is the restoring divider, which retires one quotient
// bit of the 36-bit fraction product in each stage.
// Reset clears all valid bits and loads the high reference with 26 MHz.
// When a result waits on rsp, the whole pipeline holds; nothing is dropped.
//
module fractional_pll_rate_calc_core (
  input  logic             clk,
  input  logic             rst,
  frc_req_if.sink          req,
  frc_rsp_if.source        rsp,
  input  logic             cfg_write_en,
  input  logic [25:0]      cfg_write_data
);
  import frc_pkg::*;

  logic [RefW-1:0] high_ref_hz;
  logic            adv;
  frc_req_t        req_word;

  logic            f_valid;
  logic [35:0]     f_prod;
  logic [10:0]     f_dvs;
  frc_side_t       f_side;

  logic            d_valid;
  logic [35:0]     d_quo;
  frc_side_t       d_side;

  // The pipeline advances whenever the output register is free or drained.
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  assign req_word.ref_select       = req.ref_select;
  assign req_word.pll_enable       = req.pll_enable;
  assign req_word.pll_bypass       = req.pll_bypass;
  assign req_word.pre_divider      = req.pre_divider;
  assign req_word.frac_denominator = req.frac_denominator;
  assign req_word.integer_factor   = req.integer_factor;
  assign req_word.frac_numerator   = req.frac_numerator;
  assign req_word.bus_divider      = req.bus_divider;
  assign req_word.periph_divider   = req.periph_divider;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_ref_hz <= HighRefReset;
    end else if (cfg_write_en) begin
      high_ref_hz <= cfg_write_data;
    end
  end

  frc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (req.valid),
    .in_req      (req_word),
    .high_ref_hz (high_ref_hz),
    .out_valid   (f_valid),
    .out_prod    (f_prod),
    .out_dvs     (f_dvs),
    .out_side    (f_side)
  );

  frc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_valid),
    .in_num    (f_prod),
    .in_dvs    (f_dvs),
    .in_side   (f_side),
    .out_valid (d_valid),
    .out_quo   (d_quo),
    .out_side  (d_side)
  );

  frc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (d_valid),
    .in_frac     (d_quo),
    .in_side     (d_side),
    .out_valid   (rsp.valid),
    .out_main    (rsp.main_rate_hz),
    .out_bus     (rsp.bus_rate_hz),
    .out_per     (rsp.periph_rate_hz),
    .out_clamped (rsp.rate_clamped)
  );

endmodule

FILE: hdl/frc_checker.sv
// ----------------------------------------------------------------------------
// frc_checker
// Port-level checks of the rate calculator, bound to the top level.
// ----------------------------------------------------------------------------
module frc_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [30:0] main_rate_hz,
  input logic [30:0] bus_rate_hz,
  input logic [30:0] periph_rate_hz,
  input logic        rate_clamped
);
  import frc_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result shown right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(main_rate_hz) && $stable(bus_rate_hz)
      && $stable(periph_rate_hz) && $stable(rate_clamped))
    else $error("result changed while stalled");

  a_order: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> bus_rate_hz <= main_rate_hz && periph_rate_hz <= bus_rate_hz)
    else $error("divided rate exceeds its source");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rate_clamped |-> main_rate_hz == '0 || main_rate_hz == RateMax)
    else $error("clamped rate not at a limit");

endmodule

bind fractional_pll_rate_calc_core frc_checker u_frc_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .main_rate_hz   (rsp.main_rate_hz),
  .bus_rate_hz    (rsp.bus_rate_hz),
  .periph_rate_hz (rsp.periph_rate_hz),
  .rate_clamped   (rsp.rate_clamped)
);

FILE: verif/frc_rate_checker.sv
// ----------------------------------------------------------------------------
// frc_rate_checker
// Watches the request and result channels of the PLL rate calculator, predicts
// each result from the accepted settings and compares it field by field.
// ----------------------------------------------------------------------------
module frc_rate_checker (
  input  logic                  clk,
  input  logic                  rst,
  frc_req_if                    req,
  frc_rsp_if                    rsp,
  input  logic                  cfg_write_en,
  input  logic [frc_pkg::RefW-1:0] cfg_write_data,
  output int                    fail_count,
  output int                    pending_count
);
  import frc_pkg::*;

  typedef struct packed {
    logic [RateW-1:0] main_rate;
    logic [RateW-1:0] bus_rate;
    logic [RateW-1:0] periph_rate;
    logic             clamped;
  } rate_set_t;

  logic [RefW-1:0] high_ref;
  rate_set_t       rate_queue[$];

  function automatic rate_set_t predict_rates(input logic [RefW-1:0] hi_ref,
                                              input logic [1:0] sel,
                                              input logic en, input logic byp,
                                              input logic [3:0] pd,
                                              input logic [9:0] mfd,
                                              input logic [3:0] mfi,
                                              input logic [9:0] mfn,
                                              input logic [2:0] busd,
                                              input logic [1:0] perd);
    longint    ref_hz, f, mag, frac, total, main_rate, bus;
    longint    mfi_eff;
    rate_set_t r;
    r.clamped = 1'b0;
    ref_hz = (sel == SelLowOsc) ? 64'd33554432 : longint'(hi_ref);
    if (!en || byp) begin
      main_rate = ref_hz;
    end else begin
      f = (ref_hz * 2) / (pd + 1);
      mag = mfn[9] ? (1024 - longint'(mfn)) : longint'(mfn);
      frac = (f * mag) / (longint'(mfd) + 1);
      mfi_eff = (mfi < 5) ? 5 : longint'(mfi);
      total = f * mfi_eff;
      total = mfn[9] ? total - frac : total + frac;
      if (total < 0) begin
        main_rate = 0;
        r.clamped = 1'b1;
      end else if (total > 64'd2147483647) begin
        main_rate = 64'd2147483647;
        r.clamped = 1'b1;
      end else begin
        main_rate = total;
      end
    end
    bus = main_rate / (busd + 1);
    r.main_rate = main_rate[RateW-1:0];
    r.bus_rate = bus[RateW-1:0];
    r.periph_rate = 31'(bus / (perd + 1));
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    rate_set_t want;
    if (rst) begin
      high_ref <= HighRefReset;
      fail_count = 0;
    end else begin
      if (cfg_write_en) high_ref <= cfg_write_data;
      if (req.valid && req.ready)
        rate_queue.push_back(predict_rates(high_ref, req.ref_select, req.pll_enable,
          req.pll_bypass, req.pre_divider, req.frac_denominator, req.integer_factor,
          req.frac_numerator, req.bus_divider, req.periph_divider));
      if (rsp.valid && rsp.ready) begin
        if (rate_queue.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = rate_queue.pop_front();
          if (rsp.main_rate_hz !== want.main_rate)
            report_mismatch("main rate", rsp.main_rate_hz, want.main_rate);
          if (rsp.bus_rate_hz !== want.bus_rate)
            report_mismatch("bus rate", rsp.bus_rate_hz, want.bus_rate);
          if (rsp.periph_rate_hz !== want.periph_rate)
            report_mismatch("periph rate", rsp.periph_rate_hz, want.periph_rate);
          if (rsp.rate_clamped !== want.clamped)
            report_mismatch("clamp flag", rsp.rate_clamped, want.clamped);
        end
      end
    end
    pending_count = rate_queue.size();
  end

endmodule

FILE: verif/fractional_pll_rate_calc_core_tb.sv
// ----------------------------------------------------------------------------
// fractional_pll_rate_calc_core_tb
// Drives directed and random PLL settings through the rate calculator under
// several reference settings and idle patterns; a checker module beside the
// block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module fractional_pll_rate_calc_core_tb;
  import frc_pkg::*;

  logic            clk;
  logic            rst;
  logic            cfg_write_en;
  logic [RefW-1:0] cfg_write_data;
  int              fail_count;
  int              pending_count;
  int              cycle_count;
  int              send_idle_pct;
  int              recv_stall_pct;

  frc_req_if req ();
  frc_rsp_if rsp ();

  fractional_pll_rate_calc_core DUT (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .rsp            (rsp),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  frc_rate_checker checker_inst (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .rsp            (rsp),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .fail_count     (fail_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The run is bounded: the pipeline is 42 deep and the idle patterns are
  // random, so the cycle limit lies far beyond any correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 800000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Presents one item and holds it until accepted. The valid line stays high
  // between back-to-back items, so it is never lowered and raised in one step.
  task automatic send_item(input frc_req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid            <= 1'b1;
    req.ref_select       <= item.ref_select;
    req.pll_enable       <= item.pll_enable;
    req.pll_bypass       <= item.pll_bypass;
    req.pre_divider      <= item.pre_divider;
    req.frac_denominator <= item.frac_denominator;
    req.integer_factor   <= item.integer_factor;
    req.frac_numerator   <= item.frac_numerator;
    req.bus_divider      <= item.bus_divider;
    req.periph_divider   <= item.periph_divider;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // Waits for every expected result, then lets the pipeline drain fully.
  task automatic drain_results();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_high_ref(input logic [RefW-1:0] value);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly PLL-active settings, since they exercise the divider chain; the
  // pass-through paths still get about 3/16 of the items.
  function automatic frc_req_t random_item();
    frc_req_t item;
    item = frc_req_t'(37'({$urandom, $urandom}));
    if ($urandom_range(3) != 0) begin
      item.pll_enable = 1'b1;
      item.pll_bypass = 1'b0;
    end
    return item;
  endfunction

  task automatic send_directed();
    frc_req_t item;
    int k;
    // Extremes: maximum multiplication saturates high for large references, the
    // most negative numerator saturates low; then low factor, bypass, PLL off.
    for (k = 0; k < 20; k++) begin
      item = '0;
      item.pll_enable = 1'b1;
      item.ref_select = 2'(k);
      case (k % 5)
        0: begin
          item.integer_factor = 4'd15;
          item.frac_numerator = 10'h1FF;
          item.bus_divider = 3'd7;
          item.periph_divider = 2'd3;
        end
        1: begin
          // Largest negative fraction with the tiniest denominator drives
          // the total below zero.
          item.frac_numerator = 10'h200;
          item.pre_divider = 4'd15;
        end
        2: begin
          item.integer_factor = 4'd4;
          item.frac_denominator = 10'h3FF;
          item.frac_numerator = 10'h3FF;
          item.pre_divider = 4'(k);
        end
        3: begin
          item.pll_bypass = 1'b1;
          item.bus_divider = 3'(k);
        end
        default: begin
          item.pll_enable = 1'b0;
          item.periph_divider = 2'(k);
        end
      endcase
      send_item(item);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    int k;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (k = 0; k < count; k++) begin
      send_item(random_item());
      // Hold off once, halfway, until every result has come back.
      if (k == count / 2) drain_results();
    end
    drain_results();
  endtask

  initial begin
    rst            = 1'b1;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    req.valid            = 1'b0;
    req.ref_select       = '0;
    req.pll_enable       = 1'b0;
    req.pll_bypass       = 1'b0;
    req.pre_divider      = '0;
    req.frac_denominator = '0;
    req.integer_factor   = '0;
    req.frac_numerator   = '0;
    req.bus_divider      = '0;
    req.periph_divider   = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset value of the high reference first, then the extremes and a zero.
    send_directed();
    run_phase(0, 0, 200);
    write_high_ref(26'h3FFFFFF);
    send_directed();
    run_phase(71, 0, 300);
    write_high_ref(26'd1000000);
    send_directed();
    run_phase(0, 71, 300);
    write_high_ref(26'd0);
    run_phase(38, 38, 150);
    write_high_ref(26'($urandom_range(67108863, 1000000)));
    run_phase(38, 38, 300);
    write_high_ref(26'($urandom_range(67108863, 1000000)));
    run_phase(0, 0, 200);

    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
